// File: rtl/core/decaying_saw_voice_macros.svh
// Assertion macros for the decaying saw voice.
// Included by RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef DECAYING_SAW_VOICE_MACROS_SVH
`define DECAYING_SAW_VOICE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dsv_pkg.sv
// Shared types and constants for the decaying saw voice.
// Used by dsv_ctrl, dsv_datapath and the decaying_saw_voice top level.
package dsv_pkg;

  // Fixed-point constants (audio Q1.15, envelope Q1.24).
  localparam logic [15:0] K_DRIVE   = 16'd39322;   // 1.2 in Q1.15
  localparam logic [15:0] GAIN_HI   = 16'd8192;    // 0.25
  localparam logic [15:0] GAIN_LO   = 16'd4915;    // 0.15
  localparam logic [24:0] ENV_ONE   = 25'd16777216;
  localparam logic [18:0] LEN_LIMIT = 19'd524287;
  localparam int unsigned MAX_NOTE_SECONDS = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_STEP_PER_HZ = 2'd1;
  localparam logic [1:0] REG_DECAY       = 2'd2;
  localparam logic [1:0] REG_GAIN_MODE   = 2'd3;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CHECK,
    OP_LEN,
    OP_STEP,
    OP_DRV,
    OP_D2,
    OP_D3,
    OP_SOFT,
    OP_V,
    OP_SMP,
    OP_ENV
  } dsv_op_e;

  typedef struct packed {
    dsv_op_e op;
    logic    load_in;
    logic    load_out;
  } dsv_cmd_t;

  typedef struct packed {
    logic active;
  } dsv_stat_t;

endpackage

// File: rtl/core/dsv_datapath.sv
// Datapath of the decaying saw voice: config registers, voice state, one shared
// multiplier and the output register. Depends on dsv_pkg; driven by dsv_ctrl.
module dsv_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsv_pkg::dsv_cmd_t   cmd_i,
  output dsv_pkg::dsv_stat_t  stat_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  input  logic signed [15:0]  mix_in_left_i,
  input  logic signed [15:0]  mix_in_right_i,
  input  logic [23:0]         note_freq_i,
  input  logic [19:0]         note_duration_i,
  output logic signed [15:0]  out_left_o,
  output logic signed [15:0]  out_right_o,
  output logic                voice_active_o
);

  // Configuration registers.
  logic [17:0] sample_rate_q;
  logic [19:0] step_per_hz_q;
  logic [23:0] decay_q;
  logic        gain_mode_q;

  // Voice state.
  logic [31:0] phase_q;
  logic [31:0] step_q;
  logic [24:0] env_q;
  logic [18:0] pos_q;
  logic [18:0] len_q;

  // Latched item fields.
  logic signed [15:0] mix_l_q;
  logic signed [15:0] mix_r_q;
  logic [23:0]        freq_q;
  logic [19:0]        dur_q;

  // Intermediate results.
  logic [21:0]        len_tmp_q;
  logic               voice_q;
  logic signed [16:0] drv_q;
  logic signed [16:0] d2_q;
  logic signed [17:0] d3_q;
  logic signed [18:0] soft_q;
  logic signed [18:0] v_q;
  logic signed [17:0] smp_q;

  // Output register.
  logic signed [15:0] out_l_q;
  logic signed [15:0] out_r_q;
  logic               out_act_q;

  logic signed [15:0] raw;
  logic signed [15:0] gain;
  logic signed [25:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [51:0] prod;
  logic signed [51:0] rnd8;
  logic signed [51:0] rnd15;
  logic signed [51:0] rnd24;
  logic signed [19:0] soft_sum;
  logic [20:0]        cap;
  logic [21:0]        len_min;
  logic [18:0]        len_capped;
  logic signed [18:0] sum_l;
  logic signed [18:0] sum_r;

  // Saturate a widened sum back to Q1.15.
  function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
    logic signed [15:0] r;
    if (x > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -19'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // Sawtooth centered on zero: top phase bits with the sign flipped.
  assign raw  = {~phase_q[31], phase_q[30:16]};
  assign gain = gain_mode_q ? $signed(dsv_pkg::GAIN_HI) : $signed(dsv_pkg::GAIN_LO);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      dsv_pkg::OP_LEN: begin
        mul_a = 26'(dur_q);
        mul_b = 26'(sample_rate_q);
      end
      dsv_pkg::OP_STEP: begin
        mul_a = 26'(freq_q);
        mul_b = 26'(step_per_hz_q);
      end
      dsv_pkg::OP_DRV: begin
        mul_a = 26'(raw);
        mul_b = 26'(dsv_pkg::K_DRIVE);
      end
      dsv_pkg::OP_D2: begin
        mul_a = 26'(drv_q);
        mul_b = 26'(drv_q);
      end
      dsv_pkg::OP_D3: begin
        mul_a = 26'(d2_q);
        mul_b = 26'(drv_q);
      end
      dsv_pkg::OP_V: begin
        mul_a = 26'(soft_q);
        mul_b = 26'(env_q);
      end
      dsv_pkg::OP_SMP: begin
        mul_a = 26'(v_q);
        mul_b = 26'(gain);
      end
      dsv_pkg::OP_ENV: begin
        mul_a = 26'(env_q);
        mul_b = 26'(decay_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product and the round-to-nearest offsets used by the steps.
  assign prod  = mul_a * mul_b;
  assign rnd8  = prod + 52'sd128;
  assign rnd15 = prod + 52'sd16384;
  assign rnd24 = prod + 52'sd8388608;

  // Soft clip: (3*drv - d3) / 2, rounded.
  assign soft_sum = 20'(drv_q) + (20'(drv_q) <<< 1) - 20'(d3_q) + 20'sd1;

  // Note length capped at the maximum note time and at the state width.
  assign cap        = 21'(sample_rate_q) * 21'(dsv_pkg::MAX_NOTE_SECONDS);
  assign len_min    = (len_tmp_q > 22'(cap)) ? 22'(cap) : len_tmp_q;
  assign len_capped = (len_min > 22'(dsv_pkg::LEN_LIMIT)) ? dsv_pkg::LEN_LIMIT
                                                          : len_min[18:0];

  assign sum_l = 19'(mix_l_q) + 19'(smp_q);
  assign sum_r = 19'(mix_r_q) + 19'(smp_q);

  assign stat_o.active = (pos_q < len_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= 18'd48000;
      step_per_hz_q <= 20'd89478;
      decay_q       <= 24'd16775469;
      gain_mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dsv_pkg::REG_SAMPLE_RATE: sample_rate_q <= cfg_data_i[17:0];
        dsv_pkg::REG_STEP_PER_HZ: step_per_hz_q <= cfg_data_i[19:0];
        dsv_pkg::REG_DECAY:       decay_q       <= cfg_data_i;
        dsv_pkg::REG_GAIN_MODE:   gain_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Voice state: loaded by triggers, advanced after each voiced sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      env_q   <= dsv_pkg::ENV_ONE;
      pos_q   <= '0;
      len_q   <= '0;
    end else begin
      case (cmd_i.op)
        dsv_pkg::OP_STEP: begin
          step_q <= rnd8[39:8];
          len_q  <= len_capped;
          pos_q  <= '0;
          env_q  <= dsv_pkg::ENV_ONE;
        end
        dsv_pkg::OP_ENV: begin
          env_q   <= rnd24[48:24];
          phase_q <= phase_q + step_q;
          pos_q   <= pos_q + 19'd1;
        end
        default: ;
      endcase
    end
  end

  // Item fields, taken when the item is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mix_l_q <= mix_in_left_i;
      mix_r_q <= mix_in_right_i;
      freq_q  <= note_freq_i;
      dur_q   <= note_duration_i;
    end
  end

  // Intermediate results of the sample computation.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dsv_pkg::OP_CHECK: voice_q   <= stat_o.active;
      dsv_pkg::OP_LEN:   len_tmp_q <= prod[37:16];
      dsv_pkg::OP_DRV:   drv_q     <= rnd15[31:15];
      dsv_pkg::OP_D2:    d2_q      <= rnd15[31:15];
      dsv_pkg::OP_D3:    d3_q      <= rnd15[32:15];
      dsv_pkg::OP_SOFT:  soft_q    <= soft_sum[19:1];
      dsv_pkg::OP_V:     v_q       <= rnd24[42:24];
      dsv_pkg::OP_SMP:   smp_q     <= rnd15[32:15];
      default: ;
    endcase
  end

  // Output register: mix plus voice when voiced, plain mix otherwise.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_l_q   <= voice_q ? sat16(sum_l) : mix_l_q;
      out_r_q   <= voice_q ? sat16(sum_r) : mix_r_q;
      out_act_q <= voice_q;
    end
  end

  assign out_left_o     = out_l_q;
  assign out_right_o    = out_r_q;
  assign voice_active_o = out_act_q;

endmodule

// File: rtl/core/dsv_ctrl.sv
// Controller of the decaying saw voice: sequences the datapath steps and owns
// the input stall and output valid. Depends on dsv_pkg and the macros header.
`include "decaying_saw_voice_macros.svh"

module dsv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dsv_pkg::dsv_stat_t  stat_i,
  output dsv_pkg::dsv_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_LEN   = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_DRV   = 4'd4;
  localparam logic [3:0] S_D2    = 4'd5;
  localparam logic [3:0] S_D3    = 4'd6;
  localparam logic [3:0] S_SOFT  = 4'd7;
  localparam logic [3:0] S_V     = 4'd8;
  localparam logic [3:0] S_SMP   = 4'd9;
  localparam logic [3:0] S_ENV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       in_accept;
  logic       slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Next state and datapath command.
  always_comb begin
    state_d        = state_q;
    cmd_o.op       = dsv_pkg::OP_NONE;
    cmd_o.load_in  = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = req_type_i ? S_LEN : S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.op = dsv_pkg::OP_CHECK;
        state_d  = stat_i.active ? S_DRV : S_OUT;
      end
      S_LEN: begin
        cmd_o.op = dsv_pkg::OP_LEN;
        state_d  = S_STEP;
      end
      S_STEP: begin
        cmd_o.op = dsv_pkg::OP_STEP;
        state_d  = S_IDLE;
      end
      S_DRV: begin
        cmd_o.op = dsv_pkg::OP_DRV;
        state_d  = S_D2;
      end
      S_D2: begin
        cmd_o.op = dsv_pkg::OP_D2;
        state_d  = S_D3;
      end
      S_D3: begin
        cmd_o.op = dsv_pkg::OP_D3;
        state_d  = S_SOFT;
      end
      S_SOFT: begin
        cmd_o.op = dsv_pkg::OP_SOFT;
        state_d  = S_V;
      end
      S_V: begin
        cmd_o.op = dsv_pkg::OP_V;
        state_d  = S_SMP;
      end
      S_SMP: begin
        cmd_o.op = dsv_pkg::OP_SMP;
        state_d  = S_ENV;
      end
      S_ENV: begin
        cmd_o.op = dsv_pkg::OP_ENV;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // Wait here until the output register can take the item.
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output item stays valid until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted item always starts a sequence.
  `DSV_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != S_IDLE,
                   "accepted item did not leave idle")
  // The output register is never overwritten while an item waits there.
  `DSV_ASSERT_NOW(a_no_overwrite, cmd_o.load_out, !out_valid_q || !out_stall_i,
                  "output register loaded while stalled")
  // A new output item only appears from the output step.
  `DSV_ASSERT_NOW(a_valid_from_out, $rose(out_valid_q), $past(state_q) == S_OUT,
                  "output valid rose outside the output step")
  // A trigger finishes without producing an output item.
  `DSV_ASSERT_NEXT(a_trigger_silent, state_q == S_STEP,
                   state_q == S_IDLE && !$rose(out_valid_q),
                   "trigger produced an output item")

endmodule

// File: rtl/core/decaying_saw_voice.sv
// Top level of the decaying saw voice: ports, config handshake, and the
// controller and datapath. Depends on dsv_pkg, dsv_ctrl and dsv_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per handshake:
//   req_type_i = 1 is a note trigger (note_freq_i, note_duration_i), 0 is a
//   sample tick (mix_in_left_i, mix_in_right_i). Only ticks give an output
//   item on out_valid_o / out_stall_i.
//   Items are handled one at a time around a single shared multiplier.
//   A trigger keeps the input stalled through its length and step states.
//   A tick outside the note goes from its check state to its output state; a
//   voiced tick first runs the seven multiply and add steps of the shared unit,
//   and the next item stays stalled at the input until the tick is done.
//   The output register keeps one finished item; when the receiver stalls,
//   the item holds steady, the next item may still be accepted and computed,
//   and a further tick waits in its output step until the register frees.
//   Config writes (cfg_valid_i, cfg_ready_o always high) go to register
//   cfg_index_i and must only happen while the block is idle.
//   Reset clears the voice (silent), the phase, and restores the default
//   register values; no clearing pass is needed.
module decaying_saw_voice (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [15:0] mix_in_left_i,
  input  logic signed [15:0] mix_in_right_i,
  input  logic [23:0]        note_freq_i,
  input  logic [19:0]        note_duration_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_right_o,
  output logic               voice_active_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  dsv_pkg::dsv_cmd_t  cmd;
  dsv_pkg::dsv_stat_t stat;
  logic               cfg_we;

  // Registers are always writable; the write lands on the same edge.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  dsv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsv_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mix_in_left_i   (mix_in_left_i),
    .mix_in_right_i  (mix_in_right_i),
    .note_freq_i     (note_freq_i),
    .note_duration_i (note_duration_i),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .voice_active_o  (voice_active_o)
  );

endmodule
